FILE: src/time_ordered_activity_queue_top_macros.svh
// Assertion macros shared by the activity queue top level.
`ifndef TIME_ORDERED_ACTIVITY_QUEUE_TOP_MACROS_SVH
`define TIME_ORDERED_ACTIVITY_QUEUE_TOP_MACROS_SVH

// condition holds whenever out of reset
`define TOAQ_ASSERT_HOLD(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define TOAQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define TOAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/toaq_pkg.sv
// Types and codes shared by the activity queue modules.
package toaq_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_OVERLAP = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  role_id;
        logic [31:0] start_time;
        logic [7:0]  priority_req;
        logic [31:0] duration_us;
    } t_in_item;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  role_id;
        logic [31:0] start_time;
        logic [7:0]  priority_req;
        logic [31:0] end_time;
    } t_op;

    typedef struct packed {
        t_status     status;
        logic        overlap;
        logic [3:0]  head_id;
        logic [31:0] head_start;
        logic [7:0]  head_priority;
        logic [3:0]  entry_count;
    } t_out_item;

endpackage

FILE: src/toaq_fifo.sv
// Two-entry item queue with push/full and pop/empty sides.
module toaq_fifo import toaq_pkg::*; #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    output logic         o_full,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_mem [2];
    logic         r_wp, r_rp;
    logic [1:0]   r_cnt;
    logic         wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

FILE: src/toaq_front.sv
// Front end: takes items, precomputes the aperiodic end time, queues ops.
module toaq_front import toaq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_push,
    output logic        o_full,
    input  t_in_item    i_item,
    input  logic        i_op_ready,
    output logic        o_op_valid,
    output t_op         o_op
);

    logic [15:0] r_switch_delay;
    t_op         op_in;
    logic        op_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch_delay <= 16'd0;
        end else if (i_cfg_we) begin
            r_switch_delay <= i_cfg_wdata;
        end
    end

    always_comb begin
        op_in.cmd          = i_item.cmd;
        op_in.role_id      = i_item.role_id;
        op_in.start_time   = i_item.start_time;
        op_in.priority_req = i_item.priority_req;
        op_in.end_time     = i_item.start_time + i_item.duration_us
                           + {16'd0, r_switch_delay};
    end

    toaq_fifo #(.W($bits(t_op))) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_data  (op_in),
        .i_pop   (i_op_ready),
        .o_empty (op_empty),
        .o_data  (o_op)
    );

    assign o_op_valid = !op_empty;

endmodule

FILE: src/toaq_exec.sv
// Back end: sorted slot table, executes one op per cycle while the result queue has room.
module toaq_exec import toaq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8,
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  t_op           i_op,
    input  logic          i_res_room,
    output logic          o_fire,
    output t_out_item     o_res,
    output logic [CW-1:0] o_count
);

    logic [31:0]       r_start [QUEUE_DEPTH];
    logic [7:0]        r_pri   [QUEUE_DEPTH];
    logic [3:0]        r_id    [QUEUE_DEPTH];
    logic [CW-1:0]     r_count;

    logic [31:0]       n_start [QUEUE_DEPTH];
    logic [7:0]        n_pri   [QUEUE_DEPTH];
    logic [3:0]        n_id    [QUEUE_DEPTH];
    logic [CW-1:0]     n_count;

    logic [QUEUE_DEPTH-1:0] live, gt, match, ins_ge, rm_ge;
    logic              q_full, q_empty, hit, have_head, ovl;
    t_status           status;

    assign o_fire  = i_op_valid && i_res_room;
    assign o_count = r_count;

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            live[k]  = CW'(k) < r_count;
            gt[k]    = live[k] && (r_start[k] > i_op.start_time);
            match[k] = live[k] && (r_id[k] == i_op.role_id);
        end
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            ins_ge[k] = !live[k];
            rm_ge[k]  = (i_op.cmd == CMD_DEQUEUE);
            for (int j = 0; j < QUEUE_DEPTH; j++) begin
                if (j <= k) begin
                    ins_ge[k] = ins_ge[k] | gt[j];
                    rm_ge[k]  = rm_ge[k] | match[j];
                end
            end
        end
        q_full  = (r_count == CW'(QUEUE_DEPTH));
        q_empty = (r_count == '0);
        hit     = |match;

        n_start   = r_start;
        n_pri     = r_pri;
        n_id      = r_id;
        n_count   = r_count;
        status    = ST_OK;
        have_head = 1'b0;
        ovl       = 1'b0;

        unique case (i_op.cmd)
            CMD_INSERT: begin
                if (q_full) begin
                    status = ST_FULL;
                end else begin
                    if (ins_ge[0]) begin
                        n_start[0] = i_op.start_time;
                        n_pri[0]   = i_op.priority_req;
                        n_id[0]    = i_op.role_id;
                    end
                    for (int k = 1; k < QUEUE_DEPTH; k++) begin
                        if (ins_ge[k-1]) begin
                            n_start[k] = r_start[k-1];
                            n_pri[k]   = r_pri[k-1];
                            n_id[k]    = r_id[k-1];
                        end else if (ins_ge[k]) begin
                            n_start[k] = i_op.start_time;
                            n_pri[k]   = i_op.priority_req;
                            n_id[k]    = i_op.role_id;
                        end
                    end
                    n_count = r_count + CW'(1);
                end
            end
            CMD_DEQUEUE, CMD_REMOVE: begin
                if (i_op.cmd == CMD_DEQUEUE && q_empty) begin
                    status = ST_EMPTY;
                end else if (i_op.cmd == CMD_REMOVE && !hit) begin
                    status = ST_NOT_FOUND;
                end else begin
                    have_head = (i_op.cmd == CMD_DEQUEUE);
                    for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                        if (rm_ge[k]) begin
                            n_start[k] = r_start[k+1];
                            n_pri[k]   = r_pri[k+1];
                            n_id[k]    = r_id[k+1];
                        end
                    end
                    n_count = r_count - CW'(1);
                end
            end
            CMD_OVERLAP: begin
                ovl = !q_empty && (r_start[0] <= i_op.end_time)
                      && (i_op.priority_req <= r_pri[0]);
            end
            default: begin
                status = ST_OK;
            end
        endcase

        o_res.status      = status;
        o_res.overlap     = ovl;
        o_res.entry_count = 4'(n_count);
        if (have_head) begin
            o_res.head_id       = r_id[0];
            o_res.head_start    = r_start[0];
            o_res.head_priority = r_pri[0];
        end else if (n_count != '0) begin
            o_res.head_id       = n_id[0];
            o_res.head_start    = n_start[0];
            o_res.head_priority = n_pri[0];
        end else begin
            o_res.head_id       = 4'd0;
            o_res.head_start    = 32'd0;
            o_res.head_priority = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (o_fire) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_fire) begin
            r_start <= n_start;
            r_pri   <= n_pri;
            r_id    <= n_id;
        end
    end

endmodule

FILE: src/time_ordered_activity_queue_top.sv
// Top level of the time-ordered activity queue.
//
//  channel   direction  handshake           payload
//  input     in         push / full         i_item (t_in_item)
//  result    out        empty / pop         o_item (t_out_item)
//  config    in         i_cfg_we            i_cfg_wdata (switch delay, us)
//
// An item waits in the op queue, its result in the result queue; one item
// per cycle is sustained while results are popped, set by the combinational
// execute stage over the slot table. Reset clears queue pointers, occupancy
// and the switch delay; slot contents are unset until written. A stalled
// result side fills the result queue, then the op queue, then raises full.
`include "time_ordered_activity_queue_top_macros.svh"

module time_ordered_activity_queue_top import toaq_pkg::*; #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_item
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          op_valid, op_ready, rq_full, exec_fire;
    t_op           op;
    t_out_item     exec_res;
    logic [CW-1:0] exec_count;

    toaq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_op_ready  (op_ready),
        .o_op_valid  (op_valid),
        .o_op        (op)
    );

    assign op_ready = !rq_full;

    toaq_exec #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_exec (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (op_valid),
        .i_op       (op),
        .i_res_room (!rq_full),
        .o_fire     (exec_fire),
        .o_res      (exec_res),
        .o_count    (exec_count)
    );

    toaq_fifo #(.W($bits(t_out_item))) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (exec_fire),
        .o_full  (rq_full),
        .i_data  (exec_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_item)
    );

    `TOAQ_ASSERT_HOLD(a_count_bound, i_clk, i_rst_n, exec_count <= CW'(QUEUE_DEPTH), "occupancy beyond depth")
    `TOAQ_ASSERT_NEXT(a_full_keeps, i_clk, i_rst_n, exec_fire && exec_res.status == ST_FULL, $stable(exec_count), "rejected insert changed occupancy")
    `TOAQ_ASSERT_NOW(a_res_room, i_clk, i_rst_n, exec_fire, !rq_full, "result pushed into full queue")

endmodule

FILE: dv/time_ordered_activity_queue_top_tb.sv
// Testbench for the time-ordered activity queue: directed and random commands checked against a predictor.
module time_ordered_activity_queue_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import toaq_pkg::*;

    localparam int QDEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop;
    t_out_item   o_item;

    // predictor state
    logic [31:0] act_start [QDEPTH];
    logic [7:0]  act_prio  [QDEPTH];
    logic [3:0]  act_id    [QDEPTH];
    int          act_count;
    logic [15:0] switch_delay;

    t_out_item   predicted_reports[$];
    int          n_fail;
    int          cycle_count;
    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          fill_bias;

    time_ordered_activity_queue_top #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );

    always #4ns i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void drop_activity(input int pos);
        int k;
        for (k = pos; k < act_count - 1; k++) begin
            act_start[k] = act_start[k + 1];
            act_prio[k]  = act_prio[k + 1];
            act_id[k]    = act_id[k + 1];
        end
        act_count--;
    endfunction

    function automatic t_out_item predict_command(input t_in_item it);
        t_out_item   rep;
        int          pos;
        int          k;
        bit          hit;
        bit          popped;
        logic [31:0] end_time;
        rep = '0;
        popped = 1'b0;
        hit = 1'b0;
        pos = act_count;
        case (it.cmd)
            CMD_INSERT: begin
                if (act_count >= QDEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    for (k = 0; k < act_count; k++) begin
                        if (!hit && act_start[k] > it.start_time) begin
                            pos = k;
                            hit = 1'b1;
                        end
                    end
                    for (k = act_count; k > pos; k--) begin
                        act_start[k] = act_start[k - 1];
                        act_prio[k]  = act_prio[k - 1];
                        act_id[k]    = act_id[k - 1];
                    end
                    act_start[pos] = it.start_time;
                    act_prio[pos]  = it.priority_req;
                    act_id[pos]    = it.role_id;
                    act_count++;
                end
            end
            CMD_DEQUEUE: begin
                if (act_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    popped = 1'b1;
                    rep.head_id       = act_id[0];
                    rep.head_start    = act_start[0];
                    rep.head_priority = act_prio[0];
                    drop_activity(0);
                end
            end
            CMD_REMOVE: begin
                for (k = 0; k < act_count; k++) begin
                    if (!hit && act_id[k] == it.role_id) begin
                        pos = k;
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    rep.status = ST_NOT_FOUND;
                end else begin
                    drop_activity(pos);
                end
            end
            CMD_OVERLAP: begin
                if (act_count > 0) begin
                    end_time = it.start_time + it.duration_us + {16'd0, switch_delay};
                    rep.overlap = (act_start[0] <= end_time) && (it.priority_req <= act_prio[0]);
                end
            end
        endcase
        if (!popped && act_count > 0) begin
            rep.head_id       = act_id[0];
            rep.head_start    = act_start[0];
            rep.head_priority = act_prio[0];
        end
        rep.entry_count = 4'(act_count);
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_fail++;
        end
    endtask

    task automatic check_report(input t_out_item got);
        t_out_item want;
        if (predicted_reports.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual %0h", $time, got);
            n_fail++;
        end else begin
            want = predicted_reports.pop_front();
            check_field("status", want.status, got.status);
            check_field("overlap", want.overlap, got.overlap);
            check_field("head_id", want.head_id, got.head_id);
            check_field("head_start", want.head_start, got.head_start);
            check_field("head_priority", want.head_priority, got.head_priority);
            check_field("entry_count", want.entry_count, got.entry_count);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            check_report(o_item);
        end
        pop <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted_reports.push_back(predict_command(it));
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (predicted_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_switch_delay(input logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        switch_delay = value;
    endtask

    function automatic t_in_item mk_item(input t_cmd cmd, input logic [3:0] id,
                                         input logic [31:0] st, input logic [7:0] pri,
                                         input logic [31:0] dur);
        t_in_item it;
        it.cmd          = cmd;
        it.role_id      = id;
        it.start_time   = st;
        it.priority_req = pri;
        it.duration_us  = dur;
        return it;
    endfunction

    function automatic t_in_item make_random_item();
        t_in_item    it;
        int          r;
        int          off;
        logic [31:0] target;
        it = mk_item(CMD_INSERT, 4'($urandom), $urandom, 8'($urandom), $urandom);
        r = $urandom_range(0, 99);
        if (fill_bias) begin
            it.cmd = (r < 55) ? CMD_INSERT : (r < 70) ? CMD_DEQUEUE :
                     (r < 85) ? CMD_REMOVE : CMD_OVERLAP;
        end else begin
            it.cmd = (r < 20) ? CMD_INSERT : (r < 50) ? CMD_DEQUEUE :
                     (r < 75) ? CMD_REMOVE : CMD_OVERLAP;
        end
        case (it.cmd)
            CMD_INSERT: begin
                case ($urandom_range(0, 3))
                    0: it.start_time = $urandom;
                    1: it.start_time = 32'($urandom_range(0, 7) * 1000);
                    2: if (act_count > 0) it.start_time = act_start[$urandom_range(0, act_count - 1)];
                    default: it.start_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                endcase
                if ($urandom_range(0, 4) == 0) it.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            CMD_REMOVE: begin
                if (act_count > 0 && $urandom_range(0, 3) != 0) begin
                    it.role_id = act_id[$urandom_range(0, act_count - 1)];
                end
            end
            CMD_OVERLAP: begin
                if (act_count > 0 && $urandom_range(0, 9) < 7) begin
                    off = $urandom_range(0, 4) - 2;
                    target = act_start[0] + 32'(off);
                    it.duration_us = target - it.start_time - {16'd0, switch_delay};
                    case ($urandom_range(0, 2))
                        0: it.priority_req = act_prio[0];
                        1: it.priority_req = act_prio[0] + 8'd1;
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        return it;
    endfunction

    task automatic test_empty_queue();
        send_item(mk_item(CMD_DEQUEUE, 4'd0, 32'd0, 8'd0, 32'd0));
        send_item(mk_item(CMD_REMOVE, 4'd0, 32'd0, 8'd0, 32'd0));
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'd0, 8'd0, 32'hFFFF_FFFF));
    endtask

    // equal start times, duplicate ids and both ends of time and priority
    task automatic test_fill_and_full();
        send_item(mk_item(CMD_INSERT, 4'd3, 32'd100, 8'd10, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd5, 32'hFFFF_FFFF, 8'd255, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd7, 32'd0, 8'd0, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd3, 32'd100, 8'd20, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd15, 32'd50, 8'd128, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd0, 32'd100, 8'd1, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd9, 32'h7FFF_FFFF, 8'd200, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd12, 32'd0, 8'd255, 32'd0));
        send_item(mk_item(CMD_INSERT, 4'd1, 32'd10, 8'd5, 32'd0));
    endtask

    task automatic test_remove_entries();
        send_item(mk_item(CMD_REMOVE, 4'd3, 32'd0, 8'd0, 32'd0));
        send_item(mk_item(CMD_REMOVE, 4'd7, 32'd0, 8'd0, 32'd0));
        send_item(mk_item(CMD_REMOVE, 4'd12, 32'd0, 8'd0, 32'd0));
        send_item(mk_item(CMD_REMOVE, 4'd4, 32'd0, 8'd0, 32'd0));
    endtask

    // head starts at 50 with priority 128 here
    task automatic test_overlap_bounds();
        wait_idle();
        write_switch_delay(16'd0);
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'd40, 8'd128, 32'd10));
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'd40, 8'd128, 32'd9));
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'd40, 8'd129, 32'd10));
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'hFFFF_FFFF, 8'd0, 32'd51));
        wait_idle();
        write_switch_delay(16'hFFFF);
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'hFFFF_0000, 8'd0, 32'h33));
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'hFFFF_0000, 8'd0, 32'h32));
        send_item(mk_item(CMD_OVERLAP, 4'd0, 32'd0, 8'd255, 32'd0));
    endtask

    task automatic test_drain_queue();
        int i;
        for (i = 0; i < 5; i++) begin
            send_item(mk_item(CMD_DEQUEUE, 4'($urandom), $urandom, 8'($urandom), $urandom));
        end
    endtask

    task automatic test_random_traffic(input int n_items, input int tx_pct, input int rx_pct,
                                       input logic [15:0] delay);
        int i;
        wait_idle();
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        write_switch_delay(delay);
        for (i = 0; i < n_items; i++) begin
            if ($urandom_range(0, 99) < 4) fill_bias = !fill_bias;
            send_item(make_random_item());
        end
    endtask

    initial begin
        act_count    = 0;
        switch_delay = 16'd0;
        n_fail       = 0;
        cycle_count  = 0;
        tx_idle_pct  = 29;
        rx_idle_pct  = 86;
        fill_bias    = 1'b1;
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 16'd0;
        push        <= 1'b0;
        i_item      <= '0;
        pop         <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_switch_delay(16'd0);

        test_empty_queue();
        test_fill_and_full();
        test_remove_entries();
        test_overlap_bounds();
        test_drain_queue();

        test_random_traffic(483, 29, 86, 16'($urandom_range(1, 65534)));
        test_random_traffic(483, 86, 29, 16'hFFFF);
        test_random_traffic(484, 0, 0, 16'd0);

        wait_idle();
        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
